@@ sv/hmpf_pkg.sv @@
// shared types and constants of the hid message packet framer
package hmpf_pkg;

	localparam int PACKET_BYTES       = 64;
	localparam int INIT_PAYLOAD_BYTES = 57;
	localparam int CONT_PAYLOAD_BYTES = 59;
	localparam int INIT_HEADER        = 7;
	localparam int CONT_HEADER        = 5;

	localparam int INIT_ROOM = (INIT_PAYLOAD_BYTES < PACKET_BYTES - INIT_HEADER) ?
		INIT_PAYLOAD_BYTES : PACKET_BYTES - INIT_HEADER;
	localparam int CONT_ROOM = (CONT_PAYLOAD_BYTES < PACKET_BYTES - CONT_HEADER) ?
		CONT_PAYLOAD_BYTES : PACKET_BYTES - CONT_HEADER;

	localparam int POS_W  = 6;
	localparam int POS1_W = POS_W + 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = QPTR_W + 1;

	typedef enum logic [1:0] {
		REG_CHANNEL_ID     = 2'd0,
		REG_COMMAND_CODE   = 2'd1,
		REG_MESSAGE_LENGTH = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		HDR_NONE,
		HDR_INIT,
		HDR_CONT
	} hdr_kind_t;

	typedef enum logic [1:0] {
		PH_HEAD,
		PH_DATA,
		PH_PAD
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		hdr_kind_t  kind;
		logic [7:0] seq;
		logic       close;
		logic       done;
	} beat_cmd_t;

	typedef struct packed {
		logic [31:0] channel_id;
		logic [7:0]  command_code;
		logic [15:0] message_length;
	} cfg_regs_t;

endpackage

@@ sv/hmpf_front.sv @@
// front end: accepts payload beats and decides header, padding and packet close
module hmpf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        message_length,
	input  logic               restart,
	input  logic               s_valid,
	output logic               s_ready,
	input  logic [7:0]         s_data,
	output logic               push,
	output hmpf_pkg::beat_cmd_t push_cmd,
	input  logic               q_full
);
	import hmpf_pkg::*;

	logic [15:0]       bytes_sent_q;
	logic [POS_W-1:0]  packet_pos_q;
	logic [7:0]        seq_q;

	logic              accept;
	logic              active;
	logic              first;
	logic [POS1_W-1:0] hdr_len;
	logic [POS1_W-1:0] room;
	logic [POS1_W-1:0] pos;
	logic [POS1_W-1:0] pos1;
	logic [15:0]       bytes_next;
	logic              done;
	logic              stay_open;
	logic [7:0]        seq_next;

	assign active  = (message_length != 16'd0);
	assign s_ready = !active || !q_full;
	assign accept  = s_valid && s_ready;
	assign push    = accept && active;

	always_comb begin
		first      = (bytes_sent_q == 16'd0);
		hdr_len    = first ? POS1_W'(INIT_HEADER) : POS1_W'(CONT_HEADER);
		room       = first ? POS1_W'(INIT_ROOM) : POS1_W'(CONT_ROOM);
		pos        = (packet_pos_q == '0) ? hdr_len : {1'b0, packet_pos_q};
		pos1       = pos + POS1_W'(1);
		bytes_next = bytes_sent_q + 16'd1;
		done       = (bytes_next >= message_length);
		stay_open  = !done && ((pos1 - hdr_len) < room) &&
			(pos1 < POS1_W'(PACKET_BYTES));
		seq_next   = seq_q;
		push_cmd.data  = s_data;
		push_cmd.kind  = HDR_NONE;
		push_cmd.seq   = seq_q;
		push_cmd.close = !stay_open;
		push_cmd.done  = done;
		if (packet_pos_q == '0) begin
			if (first) begin
				push_cmd.kind = HDR_INIT;
				seq_next      = 8'd0;
			end else begin
				push_cmd.kind = HDR_CONT;
				seq_next      = seq_q + 8'd1;
			end
		end
		if (!stay_open && done) begin
			seq_next = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_sent_q <= '0;
			packet_pos_q <= '0;
			seq_q        <= '0;
		end else if (restart) begin
			bytes_sent_q <= '0;
			packet_pos_q <= '0;
			seq_q        <= '0;
		end else if (push) begin
			seq_q <= seq_next;
			if (stay_open) begin
				bytes_sent_q <= bytes_next;
				packet_pos_q <= pos1[POS_W-1:0];
			end else begin
				bytes_sent_q <= done ? 16'd0 : bytes_next;
				packet_pos_q <= '0;
			end
		end
	end

endmodule

@@ sv/hmpf_queue.sv @@
// short command queue between the front and back ends
module hmpf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hmpf_pkg::beat_cmd_t cmd_in,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output hmpf_pkg::beat_cmd_t head_cmd
);
	import hmpf_pkg::*;

	beat_cmd_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ sv/hmpf_back.sv @@
// back end: emits header, payload and padding bytes into the output register
module hmpf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                restart,
	input  hmpf_pkg::cfg_regs_t cfg,
	input  logic                head_valid,
	input  hmpf_pkg::beat_cmd_t head_cmd,
	output logic                pop,
	output logic                m_valid,
	input  logic                m_ready,
	output logic [7:0]          m_data,
	output logic                m_last,
	output logic                m_user
);
	import hmpf_pkg::*;

	phase_t           phase_q;
	phase_t           phase_n;
	phase_t           eff_phase;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_n;
	logic [POS_W-1:0] hdr_last;
	logic [7:0]       hdr_byte;
	logic [7:0]       out_byte;
	logic             pkt_end;
	logic             advance;
	logic             valid_q;
	logic [7:0]       data_q;
	logic             last_q;
	logic             user_q;

	assign advance = head_valid && (!valid_q || m_ready);

	always_comb begin
		eff_phase = phase_q;
		if (phase_q == PH_HEAD && head_cmd.kind == HDR_NONE) begin
			eff_phase = PH_DATA;
		end
		hdr_last = (head_cmd.kind == HDR_INIT) ? POS_W'(INIT_HEADER - 1) :
			POS_W'(CONT_HEADER - 1);
		case (pos_q)
			6'd0: hdr_byte = cfg.channel_id[31:24];
			6'd1: hdr_byte = cfg.channel_id[23:16];
			6'd2: hdr_byte = cfg.channel_id[15:8];
			6'd3: hdr_byte = cfg.channel_id[7:0];
			6'd4: hdr_byte = (head_cmd.kind == HDR_INIT) ? cfg.command_code : head_cmd.seq;
			6'd5: hdr_byte = cfg.message_length[15:8];
			6'd6: hdr_byte = cfg.message_length[7:0];
			default: hdr_byte = 8'h00;
		endcase
		out_byte = 8'h00;
		pkt_end  = 1'b0;
		pop      = 1'b0;
		phase_n  = phase_q;
		pos_n    = pos_q + POS_W'(1);
		case (eff_phase)
			PH_HEAD: begin
				out_byte = hdr_byte;
				if (pos_q == hdr_last) begin
					phase_n = PH_DATA;
				end
			end
			PH_DATA: begin
				out_byte = head_cmd.data;
				if (head_cmd.close && pos_q != LAST_POS) begin
					phase_n = PH_PAD;
				end else begin
					pkt_end = head_cmd.close;
					pop     = advance;
					phase_n = PH_HEAD;
					if (head_cmd.close) begin
						pos_n = '0;
					end
				end
			end
			PH_PAD: begin
				if (pos_q == LAST_POS) begin
					pkt_end = 1'b1;
					pop     = advance;
					phase_n = PH_HEAD;
					pos_n   = '0;
				end
			end
			default: begin
				phase_n = PH_HEAD;
				pos_n   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			pos_q   <= '0;
		end else if (restart) begin
			phase_q <= PH_HEAD;
			pos_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (m_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= out_byte;
			last_q <= pkt_end;
			user_q <= pkt_end && head_cmd.done;
		end
	end

	assign m_valid = valid_q;
	assign m_data  = data_q;
	assign m_last  = last_q;
	assign m_user  = user_q;

endmodule

@@ sv/hid_message_packet_framer.sv @@
// top level of the hid message packet framer
//
// Cuts one message into 64-byte report packets. Payload bytes enter on the
// s_axis beat channel, one byte per beat. Packet bytes leave on m_axis: the
// first packet opens with channel id (big-endian), command and length, later
// ones with channel id and a wrapping sequence number; zeros pad a short packet.
// tlast marks the last byte of a packet, tuser the last byte of the message.
// The cfg channel writes channel_id (0), command_code (1) and message_length
// (2); writing message_length restarts the message. Length zero drops input.
// A beat passes the command queue, then the output register, which sends
// one byte per cycle while the receiver is ready; a beat holds it for its
// own byte plus its header and padding bytes. Input runs at one beat per
// cycle until the 4-entry command queue between front and back end fills.
// A stalled receiver holds the output register; the queue then fills and
// s_axis_tready drops. Reset clears config, state, queue and output valid.
module hid_message_packet_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] packet_byte
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,   // [0] message_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import hmpf_pkg::*;

	cfg_regs_t cfg_q;
	logic      cfg_write;
	logic      restart;
	logic      push;
	beat_cmd_t push_cmd;
	logic      q_full;
	logic      pop;
	logic      head_valid;
	beat_cmd_t head_cmd;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign restart   = cfg_write && (cfg_index == REG_MESSAGE_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_CHANNEL_ID:     cfg_q.channel_id     <= cfg_data;
				REG_COMMAND_CODE:   cfg_q.command_code   <= cfg_data[7:0];
				REG_MESSAGE_LENGTH: cfg_q.message_length <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	hmpf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.message_length (cfg_q.message_length),
		.restart        (restart),
		.s_valid        (s_axis_tvalid),
		.s_ready        (s_axis_tready),
		.s_data         (s_axis_tdata),
		.push           (push),
		.push_cmd       (push_cmd),
		.q_full         (q_full)
	);

	hmpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.cmd_in     (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	hmpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_data     (m_axis_tdata),
		.m_last     (m_axis_tlast),
		.m_user     (m_axis_tuser)
	);

endmodule

@@ sv/hmpf_checker.sv @@
// port checker of the hid message packet framer and its bind
module hmpf_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// message end only on the closing byte of a packet
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("message end without packet end");

	// no output beat right out of reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		$stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

endmodule

bind hid_message_packet_framer hmpf_sva u_hmpf_sva (.*);

@@ verif/hmpf_checker.sv @@
// packet byte predictor and comparator for the hid message packet framer
module hmpf_checker
	import hmpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic        m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [7:0] value;
		logic       pkt_end;
		logic       msg_end;
	} framed_byte_t;

	framed_byte_t framed_q[$];

	logic [31:0] chan;
	logic [7:0]  cmd;
	logic [15:0] msg_len;
	logic [15:0] consumed;
	int          pkt_pos;
	logic [7:0]  seq;

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic emit(input logic [7:0] value, input logic pe, input logic me);
		framed_q.push_back('{value: value, pkt_end: pe, msg_end: me});
	endtask

	task automatic frame_payload_byte(input logic [7:0] data);
		bit first;
		bit done;
		int hdr;
		int room;
		int at;
		if (msg_len == 0)
			return;
		first = (consumed == 0);
		hdr   = first ? INIT_HEADER : CONT_HEADER;
		room  = first ? INIT_ROOM : CONT_ROOM;
		if (pkt_pos == 0) begin
			for (int k = 3; k >= 0; k--)
				emit(chan[8*k +: 8], 1'b0, 1'b0);
			if (first) begin
				emit(cmd, 1'b0, 1'b0);
				emit(msg_len[15:8], 1'b0, 1'b0);
				emit(msg_len[7:0], 1'b0, 1'b0);
				seq = '0;
			end else begin
				emit(seq, 1'b0, 1'b0);
				seq = seq + 8'd1;
			end
			at = hdr;
		end else begin
			at = pkt_pos;
		end
		consumed = consumed + 16'd1;
		done     = (consumed >= msg_len);
		at++;
		if (!done && (at - hdr) < room && at < PACKET_BYTES) begin
			emit(data, 1'b0, 1'b0);
			pkt_pos = at;
			return;
		end
		// packet closes here, zero padded up to its last byte if it is short
		if (at >= PACKET_BYTES) begin
			emit(data, 1'b1, done);
		end else begin
			emit(data, 1'b0, 1'b0);
			while (at < PACKET_BYTES - 1) begin
				emit(8'h00, 1'b0, 1'b0);
				at++;
			end
			emit(8'h00, 1'b1, done);
		end
		pkt_pos = 0;
		if (done) begin
			consumed = '0;
			seq      = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		framed_byte_t want;
		if (!arst_n) begin
			chan     = '0;
			cmd      = '0;
			msg_len  = '0;
			consumed = '0;
			pkt_pos  = 0;
			seq      = '0;
			framed_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (framed_q.size() == 0) begin
					$error("packet_byte %02h arrived with no beat expected", m_axis_tdata);
					errors++;
				end else begin
					want = framed_q.pop_front();
					if (m_axis_tdata !== want.value) begin
						$error("packet_byte: expected %02h, got %02h", want.value, m_axis_tdata);
						errors++;
					end
					if (m_axis_tlast !== want.pkt_end) begin
						$error("packet_end: expected %0b, got %0b", want.pkt_end, m_axis_tlast);
						errors++;
					end
					if (m_axis_tuser !== want.msg_end) begin
						$error("message_end: expected %0b, got %0b", want.msg_end, m_axis_tuser);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CHANNEL_ID: chan = cfg_data;
					REG_COMMAND_CODE: cmd = cfg_data[7:0];
					REG_MESSAGE_LENGTH: begin
						msg_len  = cfg_data[15:0];
						consumed = '0;
						pkt_pos  = 0;
						seq      = '0;
					end
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				frame_payload_byte(s_axis_tdata);
		end
		pending = framed_q.size();
	end

endmodule

@@ verif/tb.sv @@
// stimulus and verdict for the hid message packet framer
module tb;
	import hmpf_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS   = 100;
	localparam int CYCLE_LIMIT   = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data = 32'h0;

	int errors;
	int pending;
	int send_idle = 0;
	int recv_idle = 0;
	int payload_beats = 0;
	int cur_len = 0;
	int cycle_count = 0;

	hid_message_packet_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	hmpf_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (cur_len != 0)
			payload_beats++;
	endtask

	task automatic send_payload(input int count);
		repeat (count)
			send_byte(8'($urandom));
	endtask

	// stop input, let every predicted packet byte drain, then let the block go quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_length(input int len);
		write_reg(REG_MESSAGE_LENGTH, {16'($urandom), 16'(len)});
		cur_len = len;
	endtask

	task automatic write_header_regs();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			write_reg(REG_CHANNEL_ID, 32'h0000_0000);
		else if (r < 30)
			write_reg(REG_CHANNEL_ID, 32'hffff_ffff);
		else if (r < 60)
			write_reg(REG_CHANNEL_ID, $urandom);
		r = $urandom_range(99);
		if (r < 15)
			write_reg(REG_COMMAND_CODE, {24'($urandom), 8'h00});
		else if (r < 30)
			write_reg(REG_COMMAND_CODE, {24'($urandom), 8'hff});
		else if (r < 60)
			write_reg(REG_COMMAND_CODE, $urandom);
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return $urandom_range(1, 8);
		else if (r < 65)
			return $urandom_range(9, INIT_ROOM);
		else if (r < 85)
			return INIT_ROOM + CONT_ROOM * $urandom_range(0, 1) + $urandom_range(0, 2) - 1;
		return $urandom_range(INIT_ROOM + 1, INIT_ROOM + CONT_ROOM + 14);
	endfunction

	task automatic random_phase(input int s_idle, input int r_idle);
		int goal;
		int kind;
		int len;
		int part;
		bit need_len;
		send_idle = s_idle;
		recv_idle = r_idle;
		goal      = payload_beats + PHASE_ITEMS;
		need_len  = 1'b1;
		while (payload_beats < goal) begin
			write_header_regs();
			kind = $urandom_range(99);
			len  = pick_length();
			if (kind < 55 || len < 2) begin
				// complete message, sometimes reusing the current length
				if (need_len || cur_len == 0 || $urandom_range(1))
					write_length(len);
				send_payload(cur_len);
				need_len = 1'b0;
			end else if (kind < 75) begin
				// header registers may be rewritten part way through a message
				part = $urandom_range(1, len - 1);
				write_length(len);
				send_payload(part);
				write_header_regs();
				send_payload(len - part);
				need_len = 1'b0;
			end else if (kind < 90) begin
				// abandoned message, restarted by the next length write
				write_length(len);
				send_payload($urandom_range(1, len - 1));
				need_len = 1'b1;
			end else begin
				if ($urandom_range(1))
					write_reg(REG_UNUSED, $urandom);
				write_length(0);
				send_payload($urandom_range(1, 3));
				need_len = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length still zero after reset, input dropped
		send_byte(8'h00);
		send_byte(8'hff);
		write_reg(REG_UNUSED, 32'hffff_ffff);
		send_byte(8'ha5);

		// one-byte messages with all-ones channel id and command, then again with the same registers
		write_reg(REG_CHANNEL_ID, 32'hffff_ffff);
		write_reg(REG_COMMAND_CODE, 32'hffff_ffff);
		write_reg(REG_MESSAGE_LENGTH, 32'hffff_0001);
		cur_len = 1;
		send_byte(8'hff);
		send_byte(8'h00);

		// longest length, cut short by a new length write
		write_reg(REG_CHANNEL_ID, 32'h0000_0000);
		write_reg(REG_COMMAND_CODE, 32'h0000_0000);
		write_length(16'hffff);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h5a);
		write_length(2);
		send_byte(8'h3c);
		send_byte(8'hc3);

		// header registers rewritten in the middle of a message
		write_length(3);
		send_byte(8'h01);
		write_reg(REG_CHANNEL_ID, 32'h0123_4567);
		write_reg(REG_COMMAND_CODE, 32'h0000_0080);
		send_byte(8'h80);
		send_byte(8'h7f);
		send_byte(8'h11);
		send_byte(8'hee);
		send_byte(8'h22);

		random_phase(33, 80);
		random_phase(80, 33);
		random_phase(0, 0);

		settle();
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ hid_message_packet_framer.f @@
sv/hmpf_pkg.sv
sv/hmpf_front.sv
sv/hmpf_queue.sv
sv/hmpf_back.sv
sv/hid_message_packet_framer.sv
sv/hmpf_checker.sv
verif/hmpf_checker.sv
verif/tb.sv
